### hdl/multi_channel_countdown_timer_bank_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the countdown timer bank
// Concurrent check macros that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_DEFINES_SVH

`ifndef SYNTHESIS
`define MCCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MCCT_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define MCCT_ASSERT(lbl, clk, rst, prop, msg)
`define MCCT_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif

`endif

### hdl/mcct_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared constants, command codes and the queue entry type.
// ----------------------------------------------------------------------------
package mcct_pkg;

   localparam int DEF_NUM_TIMERS  = 8;
   localparam int DEF_COUNT_WIDTH = 31;

   localparam int MODE_W     = 2;
   localparam int ID_W       = 3;
   localparam int INTERVAL_W = 31;
   localparam int VALUE_W    = 32;
   localparam int MASK_W     = 8;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SET   = 2'd3;

   localparam logic CSR_PERIODIC = 1'b0;
   localparam logic CSR_NOTIFY   = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ID_W-1:0]    timer_id;
      logic [VALUE_W-1:0] value;
   } qentry_type;

endpackage

### hdl/multi_channel_countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// Multi-channel countdown timer bank
// Bank of countdown timers driven by command and tick items.
// ----------------------------------------------------------------------------
// The req channel carries one item per command: mode in req_tuser, timer id
// and interval in req_tdata. Commands name one timer; a tick counts down
// every running timer. Each notified expiry of a tick leaves on the rsp
// channel as one item with the timer index in rsp_tdata, in ascending order,
// and rsp_tlast marks the final report of that tick. Ticks without reports
// and all commands produce no rsp item.
// Accepted items pass into a four-entry queue. The timer core takes one
// queue entry per cycle while it is not reporting; a command is applied
// when its entry leaves the queue. A tick updates every running timer in
// the cycle it leaves the queue and then emits one report per cycle while
// the output register is free, up to eight reports; the core takes no
// further queue entry until the last report has been emitted.
// When rsp_tready is low the output register holds its item and the core
// waits; the queue keeps taking items until it is full.
// Reset clears both mask registers, loads every count and reload value with
// one, stops every timer and empties the queue.
// The csr port writes periodic_mask at index 0 and notify_mask at index 1.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_bank #(
   parameter int NUM_TIMERS  = mcct_pkg::DEF_NUM_TIMERS,
   parameter int COUNT_WIDTH = mcct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [mcct_pkg::MASK_W-1:0]      csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mcct_pkg::REQ_TDATA_W-1:0] req_tdata,  // timer_id, interval, zero pad
   input  logic [mcct_pkg::MODE_W-1:0]      req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mcct_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // expired_timer, zero pad
   output logic                             rsp_tlast   // last
);
   import mcct_pkg::*;

   logic       push;
   qentry_type push_entry;
   logic       queue_full;
   logic       q_pop;
   logic       q_valid;
   qentry_type q_entry;

   mcct_front #(
      .NUM_TIMERS  (NUM_TIMERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   mcct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   mcct_back #(
      .NUM_TIMERS  (NUM_TIMERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hdl/mcct_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts items, drops commands for absent timers and prepares the interval.
// ----------------------------------------------------------------------------
module mcct_front #(
   parameter int NUM_TIMERS  = mcct_pkg::DEF_NUM_TIMERS,
   parameter int COUNT_WIDTH = mcct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mcct_pkg::REQ_TDATA_W-1:0] req_tdata,  // timer_id, interval, zero pad
   input  logic [mcct_pkg::MODE_W-1:0]      req_tuser,  // mode
   output logic                             push,
   output mcct_pkg::qentry_type             push_entry,
   input  logic                             queue_full
);
   import mcct_pkg::*;

   logic [ID_W-1:0]        timer_id;
   logic [VALUE_W-1:0]     ivl_ext;
   logic [COUNT_WIDTH-1:0] ivl_cut;
   logic                   keep;

   assign timer_id = req_tdata[ID_W-1:0];
   assign ivl_ext  = VALUE_W'(req_tdata[ID_W +: INTERVAL_W]);
   assign ivl_cut  = ivl_ext[COUNT_WIDTH-1:0];
   assign keep     = (req_tuser == MODE_TICK) || (32'(timer_id) < NUM_TIMERS);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && keep;

   always_comb begin
      push_entry.mode     = req_tuser;
      push_entry.timer_id = timer_id;
      if (ivl_cut == '0) begin
         push_entry.value = VALUE_W'(1);
      end else begin
         push_entry.value = VALUE_W'(ivl_cut);
      end
   end

endmodule

### hdl/mcct_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the front end and the timer core.
// ----------------------------------------------------------------------------
module mcct_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcct_pkg::qentry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output mcct_pkg::qentry_type pop_entry
);
   import mcct_pkg::*;

   qentry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/mcct_back.sv
// ----------------------------------------------------------------------------
// Timer core
// Holds the timer lanes, executes queued commands and reports expiries.
// ----------------------------------------------------------------------------
`include "multi_channel_countdown_timer_bank_defines.svh"

module mcct_back #(
   parameter int NUM_TIMERS  = mcct_pkg::DEF_NUM_TIMERS,
   parameter int COUNT_WIDTH = mcct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [mcct_pkg::MASK_W-1:0]      csr_wdata,
   input  logic                             q_valid,
   input  mcct_pkg::qentry_type             q_entry,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mcct_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // expired_timer, zero pad
   output logic                             rsp_tlast   // last
);
   import mcct_pkg::*;

   localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int RW  = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REPORT = 1'b1;

   logic [COUNT_WIDTH-1:0] count_ff  [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] count_in  [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] reload_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] reload_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  running_ff, running_in;
   logic [MASK_W-1:0]      periodic_ff, notify_ff;
   logic                   state_ff, state_in;
   logic [RW-1:0]          rep_mask_ff, rep_mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [NUM_TIMERS-1:0]  expiry;
   logic [NUM_TIMERS-1:0]  periodic_lane;
   logic [IDW-1:0]         idx;
   logic [COUNT_WIDTH-1:0] cmd_value;
   logic                   out_free;
   logic [ID_W-1:0]        low_id;
   logic [RW-1:0]          low_bit;
   logic                   found;

   assign idx       = IDW'(8'(q_entry.timer_id));
   assign cmd_value = q_entry.value[COUNT_WIDTH-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         expiry[i] = running_ff[i] && (count_ff[i] <= COUNT_WIDTH'(1));
         periodic_lane[i] = (i < MASK_W) ? periodic_ff[i % MASK_W] : 1'b0;
      end
   end

   always_comb begin
      found   = 1'b0;
      low_id  = '0;
      low_bit = '0;
      for (int i = 0; i < RW; i++) begin
         if (rep_mask_ff[i] && !found) begin
            found      = 1'b1;
            low_id     = ID_W'(i);
            low_bit[i] = 1'b1;
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      reload_in    = reload_ff;
      running_in   = running_ff;
      state_in     = state_ff;
      rep_mask_in  = rep_mask_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.mode)
                  MODE_START: begin
                     running_in[idx] = 1'b1;
                  end
                  MODE_STOP: begin
                     running_in[idx] = 1'b0;
                     count_in[idx]   = reload_ff[idx];
                  end
                  MODE_SET: begin
                     reload_in[idx] = cmd_value;
                     count_in[idx]  = cmd_value;
                  end
                  default: begin
                     for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (running_ff[i]) begin
                           if (expiry[i]) begin
                              count_in[i] = reload_ff[i];
                              if (!periodic_lane[i]) begin
                                 running_in[i] = 1'b0;
                              end
                           end else begin
                              count_in[i] = count_ff[i] - COUNT_WIDTH'(1);
                           end
                        end
                     end
                     rep_mask_in = expiry[RW-1:0] & notify_ff[RW-1:0];
                     if (rep_mask_in != '0) begin
                        state_in = ST_REPORT;
                     end
                  end
               endcase
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = low_id;
               rsp_last_in  = ((rep_mask_ff & (rep_mask_ff - RW'(1))) == '0);
               rep_mask_in  = rep_mask_ff & ~low_bit;
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_ff[i]  <= COUNT_WIDTH'(1);
            reload_ff[i] <= COUNT_WIDTH'(1);
         end
         running_ff   <= '0;
         periodic_ff  <= '0;
         notify_ff    <= '0;
         state_ff     <= ST_IDLE;
         rep_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         running_ff   <= running_in;
         state_ff     <= state_in;
         rep_mask_ff  <= rep_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && (csr_index == CSR_PERIODIC)) begin
            periodic_ff <= csr_wdata;
         end
         if (csr_wr_en && (csr_index == CSR_NOTIFY)) begin
            notify_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_id_ff);
   assign rsp_tlast  = rsp_last_ff;

   `MCCT_ASSERT(a_report_has_work, clock, reset,
      (state_ff != ST_REPORT) || (rep_mask_ff != '0), "report state with no pending expiry")
   `MCCT_ASSERT(a_pop_only_idle, clock, reset,
      !q_pop || (state_ff == ST_IDLE), "queue popped while reporting")
   `MCCT_ASSERT_NEXT(a_last_ends_report, clock, reset,
      (state_ff == ST_REPORT) && out_free && rsp_last_in,
      (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast, "final report did not end the tick")

endmodule

### tb/multi_channel_countdown_timer_bank_checker.sv
// ----------------------------------------------------------------------------
// Countdown timer bank checker
// Watches the csr, req and rsp channels, keeps its own copy of every timer
// and both masks, predicts the expiry reports of each tick item and compares
// every rsp item with the oldest pending report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_channel_countdown_timer_bank_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [mcct_pkg::MASK_W-1:0]      csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mcct_pkg::REQ_TDATA_W-1:0] req_tdata,  // timer_id, interval, zero pad
   input  logic [mcct_pkg::MODE_W-1:0]      req_tuser,  // mode
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mcct_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // expired_timer, zero pad
   input  logic                             rsp_tlast,  // last
   output int                               mismatches,
   output int                               expiries_pending,
   output int                               reports_checked
);
   import mcct_pkg::*;

   localparam int TIMERS  = DEF_NUM_TIMERS;
   localparam int COUNT_W = DEF_COUNT_WIDTH;

   typedef struct {
      logic [ID_W-1:0] timer;
      logic            closes_tick;
   } expiry_report_type;

   logic [COUNT_W-1:0] ticks_left [TIMERS];
   logic [COUNT_W-1:0] reload_ticks [TIMERS];
   logic               running [TIMERS];
   logic [MASK_W-1:0]  periodic_bits;
   logic [MASK_W-1:0]  notify_bits;
   expiry_report_type  expiry_queue [$];

   task automatic clear_bank();
      periodic_bits = '0;
      notify_bits   = '0;
      for (int i = 0; i < TIMERS; i++) begin
         ticks_left[i]   = COUNT_W'(1);
         reload_ticks[i] = COUNT_W'(1);
         running[i]      = 1'b0;
      end
      expiry_queue.delete();
   endtask

   task automatic predict_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                               input logic [INTERVAL_W-1:0] ticks);
      int                queued_before;
      expiry_report_type report;
      queued_before = expiry_queue.size();
      case (mode)
         MODE_START: begin
            running[id] = 1'b1;
         end
         MODE_STOP: begin
            running[id]    = 1'b0;
            ticks_left[id] = reload_ticks[id];
         end
         MODE_SET: begin
            if (ticks[COUNT_W-1:0] == '0) begin
               ticks = INTERVAL_W'(1);
            end
            reload_ticks[id] = ticks[COUNT_W-1:0];
            ticks_left[id]   = ticks[COUNT_W-1:0];
         end
         MODE_TICK: begin
            for (int i = 0; i < TIMERS; i++) begin
               if (running[i]) begin
                  if (ticks_left[i] > 1) begin
                     ticks_left[i] = ticks_left[i] - 1'b1;
                  end else begin
                     if (notify_bits[i]) begin
                        report.timer       = i[ID_W-1:0];
                        report.closes_tick = 1'b0;
                        expiry_queue.insert(expiry_queue.size(), report);
                     end
                     ticks_left[i] = reload_ticks[i];
                     if (!periodic_bits[i]) begin
                        running[i] = 1'b0;
                     end
                  end
               end
            end
            if (expiry_queue.size() > queued_before) begin
               expiry_queue[$].closes_tick = 1'b1;
            end
         end
      endcase
   endtask

   initial begin
      mismatches       = 0;
      expiries_pending = 0;
      reports_checked  = 0;
      clear_bank();
   end

   always @(posedge clock) begin
      expiry_report_type oldest;
      if (reset) begin
         clear_bank();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_PERIODIC) begin
               periodic_bits = csr_wdata;
            end else begin
               notify_bits = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            reports_checked++;
            if (expiry_queue.size() == 0) begin
               $error("Unexpected report: expired_timer %0d, last %0b",
                      rsp_tdata[ID_W-1:0], rsp_tlast);
               mismatches++;
            end else begin
               oldest = expiry_queue.pop_front();
               if (rsp_tdata[ID_W-1:0] !== oldest.timer) begin
                  $error("expired_timer mismatch: expected %0d, actual %0d",
                         oldest.timer, rsp_tdata[ID_W-1:0]);
                  mismatches++;
               end
               if (rsp_tlast !== oldest.closes_tick) begin
                  $error("last mismatch: expected %0b, actual %0b", oldest.closes_tick, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser, req_tdata[ID_W-1:0], req_tdata[ID_W +: INTERVAL_W]);
         end
      end
      expiries_pending = expiry_queue.size();
   end

endmodule

### tb/multi_channel_countdown_timer_bank_test.sv
// ----------------------------------------------------------------------------
// Countdown timer bank testbench
// Drives directed and random command and tick items with random gaps on both
// channels, changes the masks between phases while the bank is idle and lets
// the checker judge every expiry report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_channel_countdown_timer_bank_test;
   import mcct_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 57;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic                   csr_index;
   logic [MASK_W-1:0]      csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [MODE_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   int mismatches;
   int expiries_pending;
   int reports_checked;
   int tick_items;
   int command_items;
   int mask_settings;
   bit tx_steady;
   bit rsp_steady;

   multi_channel_countdown_timer_bank dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   multi_channel_countdown_timer_bank_checker expiry_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .mismatches       (mismatches),
      .expiries_pending (expiries_pending),
      .reports_checked  (reports_checked)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                            input logic [INTERVAL_W-1:0] ticks);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_TDATA_W - ID_W - INTERVAL_W){1'b0}}, ticks, id};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (mode == MODE_TICK) begin
         tick_items++;
      end else begin
         command_items++;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      wait (expiries_pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_masks(input logic [MASK_W-1:0] periodic, input logic [MASK_W-1:0] notify);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PERIODIC;
      csr_wdata <= periodic;
      @(negedge clock);
      csr_index <= CSR_NOTIFY;
      csr_wdata <= notify;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mask_settings++;
   endtask

   task automatic send_random_item();
      int                  pick;
      logic [ID_W-1:0]     id;
      logic [INTERVAL_W-1:0] ticks;
      pick  = $urandom_range(0, 99);
      id    = ID_W'($urandom_range(0, 7));
      ticks = ($urandom_range(0, 9) == 0) ? INTERVAL_W'($urandom) :
                                            INTERVAL_W'($urandom_range(1, 6));
      if (pick < 45) begin
         send_item(MODE_TICK, id, ticks);
      end else if (pick < 65) begin
         send_item(MODE_START, id, ticks);
      end else if (pick < 75) begin
         send_item(MODE_STOP, id, ticks);
      end else begin
         send_item(MODE_SET, id, ticks);
      end
   endtask

   // Receiver side: a random stall before each rsp item, none while steady.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [MASK_W-1:0] periodic;
      logic [MASK_W-1:0] notify;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_PERIODIC;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_TICK;
      tick_items    = 0;
      command_items = 0;
      mask_settings = 0;
      tx_steady     = 1'b0;
      rsp_steady    = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(MODE_TICK, 3'd0, 31'd1);
      settle();
      write_masks(8'h00, 8'hFF);
      send_item(MODE_SET, 3'd0, 31'd0);
      send_item(MODE_START, 3'd0, 31'd1);
      send_item(MODE_TICK, 3'd0, 31'd1);
      send_item(MODE_TICK, 3'd0, 31'd1);
      send_item(MODE_SET, 3'd7, 31'h7FFF_FFFF);
      send_item(MODE_START, 3'd7, 31'd1);
      send_item(MODE_TICK, 3'd7, 31'd1);
      send_item(MODE_STOP, 3'd7, 31'd1);
      send_item(MODE_SET, 3'd3, 31'd2);
      send_item(MODE_START, 3'd3, 31'd1);
      send_item(MODE_TICK, 3'd3, 31'd1);
      send_item(MODE_STOP, 3'd3, 31'd1);
      send_item(MODE_START, 3'd3, 31'd1);
      send_item(MODE_TICK, 3'd3, 31'd1);
      send_item(MODE_TICK, 3'd3, 31'd1);
      send_item(MODE_START, 3'd1, 31'd1);
      send_item(MODE_START, 3'd2, 31'd1);
      send_item(MODE_START, 3'd4, 31'd1);
      send_item(MODE_TICK, 3'd4, 31'd1);
      settle();
      write_masks(8'h0F, 8'h55);
      send_item(MODE_START, 3'd0, 31'd1);
      send_item(MODE_START, 3'd1, 31'd1);
      send_item(MODE_START, 3'd2, 31'd1);
      send_item(MODE_TICK, 3'd0, 31'd1);
      send_item(MODE_TICK, 3'd0, 31'd1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin periodic = 8'hFF; notify = 8'hFF; end
            1: begin periodic = 8'h00; notify = 8'hFF; end
            2: begin periodic = MASK_W'($urandom); notify = MASK_W'($urandom); end
            3: begin periodic = 8'hFF; notify = 8'h00; end
            4: begin periodic = MASK_W'($urandom); notify = 8'hFF; end
            default: begin periodic = 8'h3C; notify = 8'hC3; end
         endcase
         settle();
         write_masks(periodic, notify);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) begin
               tx_steady  = ($urandom_range(0, 3) == 0);
               rsp_steady = ($urandom_range(0, 3) == 0);
            end
            send_random_item();
         end
      end

      settle();
      $display("Sent %0d ticks and %0d timer commands under %0d mask settings.",
               tick_items, command_items, mask_settings);
      $display("Checked %0d expiry reports against the predicted bank state.", reports_checked);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
